// ===== sv/fdsa_pkg.sv =====
// Package for the file directory sector allocator.
// Holds operation and status codes and the sequencer state type.
// No dependencies.
package fdsa_pkg;

    typedef enum logic [1:0] {
        FN_LOOKUP = 2'd0,
        FN_CREATE = 2'd1,
        FN_DELETE = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_DIR_FULL  = 3'd3,
        ST_TOO_MANY  = 3'd4,
        ST_BAD_NAME  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_LIST_RD,
        S_LIST_OUT,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_ERR
    } t_state;

    localparam int NAME_W   = 48;
    localparam int SECTOR_W = 8;
    localparam int COUNT_W  = 5;

endpackage

// ===== sv/file_directory_sector_allocator_core.sv =====
// Flat file directory with a sector used/free map.
// Depends on fdsa_pkg and fdsa_ram.
//
// Input channel (i_in_valid / o_in_ready) takes one request: lookup, create
// or delete of a named file. Output channel (o_out_valid / i_out_ready)
// returns one transaction per sector listed or allocated, or a single
// transaction carrying an error or an empty-file status; o_last marks the
// final one. Function code 3 is taken and produces nothing.
// o_in_ready is high only while the sequencer is idle; one request is in
// work at a time. After acceptance a request passes through decode, a
// directory scan of up to DIR_ENTRIES entries, then a read and an output
// step per listed sector (lookup, delete) or a read and a check step per
// map sector examined (create, up to DISK_SECTORS-1 sectors), as each RAM
// has one registered read port. Errors and empty files go out from S_ERR.
// The free-sector count is kept in a register, so the space check is free.
// After reset a pass clears all DISK_SECTORS map entries but marks sector 0
// used; no request is taken meanwhile. A stalled receiver holds the sequencer
// at the point where it wants to deliver the next transaction.
module file_directory_sector_allocator_core #(
    parameter int DIR_ENTRIES      = 16,
    parameter int NAME_BYTES       = 6,
    parameter int SECTORS_PER_FILE = 26,
    parameter int DISK_SECTORS     = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_func,
    input  logic [fdsa_pkg::NAME_W-1:0]   i_file_name,
    input  logic [fdsa_pkg::COUNT_W-1:0]  i_sector_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fdsa_pkg::SECTOR_W-1:0] o_sector,
    output logic                          o_sector_valid,
    output logic [2:0]                    o_status,
    output logic [fdsa_pkg::COUNT_W-1:0]  o_count,
    output logic                          o_last
);
    import fdsa_pkg::*;

    localparam int EW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int LD = DIR_ENTRIES * SECTORS_PER_FILE;
    localparam int LW = (LD > 1) ? $clog2(LD) : 1;
    localparam int CW = $clog2(SECTORS_PER_FILE + 1);
    localparam int MW = $clog2(DISK_SECTORS);
    localparam int SW = MW + 1;
    localparam int NB = (NAME_BYTES < 6) ? NAME_BYTES : 6;
    localparam logic [EW-1:0] E_LAST = EW'(DIR_ENTRIES - 1);
    localparam logic [SW-1:0] S_END  = SW'(DISK_SECTORS - 1);

    t_state                r_state, n_state;
    logic [1:0]            r_func, n_func;
    logic [NAME_W-1:0]     r_name, n_name;
    logic [COUNT_W-1:0]    r_want, n_want;
    logic [EW-1:0]         r_e, n_e;
    logic [CW-1:0]         r_f, n_f;
    logic [CW-1:0]         r_fcnt, n_fcnt;
    logic [SW-1:0]         r_s, n_s;
    logic [MW-1:0]         r_free, n_free;
    t_status               r_err, n_err;
    logic [NAME_W-1:0]     r_names [DIR_ENTRIES];
    logic [CW-1:0]         r_cnt [DIR_ENTRIES];

    logic                  r_out_valid, n_out_valid;
    logic [SECTOR_W-1:0]   r_sector, n_sector;
    logic                  r_sector_valid, n_sector_valid;
    logic [2:0]            r_status, n_status;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic                  r_last, n_last;

    logic                  dir_we, dir_clr;
    logic [NAME_W-1:0]     norm_name;
    logic                  can_emit;
    logic                  map_we, map_wdata, map_rdata;
    logic [MW-1:0]         map_waddr;
    logic                  list_we;
    logic [SECTOR_W-1:0]   list_rdata;
    logic [LW-1:0]         list_addr;
    logic                  occupied, matched, list_last;

    // Bytes after the first zero byte are dropped.
    always_comb begin
        logic stop;
        stop      = 1'b0;
        norm_name = '0;
        for (int i = 0; i < NB; i++) begin
            if (i_file_name[8*i +: 8] == 8'd0) begin
                stop = 1'b1;
            end
            if (!stop) begin
                norm_name[8*i +: 8] = i_file_name[8*i +: 8];
            end
        end
    end

    assign list_addr = LW'(LW'(r_e) * LW'(SECTORS_PER_FILE) + LW'(r_f));
    assign occupied  = (r_names[r_e][7:0] != 8'd0);
    assign matched   = (r_func == FN_CREATE) ? !occupied
                                             : (occupied && r_names[r_e] == r_name);
    assign list_last = ((CW+1)'(r_f) + (CW+1)'(1)) == (CW+1)'(r_fcnt);
    assign can_emit  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    fdsa_ram #(.WIDTH(1), .DEPTH(DISK_SECTORS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (r_s[MW-1:0]),
        .o_rdata (map_rdata)
    );

    fdsa_ram #(.WIDTH(SECTOR_W), .DEPTH(LD)) u_list (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_addr),
        .i_wdata (SECTOR_W'(r_s)),
        .i_raddr (list_addr),
        .o_rdata (list_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_s         <= '0;
            r_free      <= MW'(DISK_SECTORS - 1);
            r_out_valid <= 1'b0;
            for (int i = 0; i < DIR_ENTRIES; i++) begin
                r_names[i] <= '0;
                r_cnt[i]   <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_s         <= n_s;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
            if (dir_we) begin
                r_names[r_e] <= r_name;
                r_cnt[r_e]   <= CW'(r_want);
            end else if (dir_clr) begin
                r_names[r_e] <= '0;
                r_cnt[r_e]   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func         <= n_func;
        r_name         <= n_name;
        r_want         <= n_want;
        r_e            <= n_e;
        r_f            <= n_f;
        r_fcnt         <= n_fcnt;
        r_err          <= n_err;
        r_sector       <= n_sector;
        r_sector_valid <= n_sector_valid;
        r_status       <= n_status;
        r_count        <= n_count;
        r_last         <= n_last;
    end

    always_comb begin
        logic                emit;
        logic [SECTOR_W-1:0] e_sec;
        logic                e_valid;
        logic [2:0]          e_status;
        logic [COUNT_W-1:0]  e_count;
        logic                e_last;

        emit     = 1'b0;
        e_sec    = '0;
        e_valid  = 1'b0;
        e_status = ST_OK;
        e_count  = '0;
        e_last   = 1'b1;

        n_state   = r_state;
        n_func    = r_func;
        n_name    = r_name;
        n_want    = r_want;
        n_e       = r_e;
        n_f       = r_f;
        n_fcnt    = r_fcnt;
        n_s       = r_s;
        n_free    = r_free;
        n_err     = r_err;
        dir_we    = 1'b0;
        dir_clr   = 1'b0;
        map_we    = 1'b0;
        map_waddr = r_s[MW-1:0];
        map_wdata = 1'b0;
        list_we   = 1'b0;

        case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_wdata = (r_s == '0);
                n_s       = r_s + SW'(1);
                if (r_s == S_END) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_func;
                    n_name  = norm_name;
                    n_want  = i_sector_count;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_e = '0;
                n_f = '0;
                n_s = SW'(1);
                if (r_func == FN_NONE) begin
                    n_state = S_IDLE;
                end else if (r_name[7:0] == 8'd0) begin
                    n_err   = ST_BAD_NAME;
                    n_state = S_ERR;
                end else if (r_func == FN_CREATE &&
                             32'(r_want) > 32'(SECTORS_PER_FILE)) begin
                    n_err   = ST_TOO_MANY;
                    n_state = S_ERR;
                end else if (r_func == FN_CREATE && 32'(r_free) < 32'(r_want)) begin
                    n_err   = ST_NO_SPACE;
                    n_state = S_ERR;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (matched) begin
                    n_err = ST_OK;
                    if (r_func == FN_CREATE) begin
                        dir_we  = 1'b1;
                        n_state = (r_want == '0) ? S_ERR : S_ALLOC_RD;
                    end else begin
                        n_fcnt = r_cnt[r_e];
                        if (r_cnt[r_e] == '0) begin
                            dir_clr = (r_func == FN_DELETE);
                            n_state = S_ERR;
                        end else begin
                            n_state = S_LIST_RD;
                        end
                    end
                end else if (r_e == E_LAST) begin
                    n_err   = (r_func == FN_CREATE) ? ST_DIR_FULL : ST_NOT_FOUND;
                    n_state = S_ERR;
                end else begin
                    n_e = r_e + EW'(1);
                end
            end
            S_LIST_RD: begin
                n_state = S_LIST_OUT;
            end
            S_LIST_OUT: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    e_sec    = list_rdata;
                    e_valid  = 1'b1;
                    e_count  = COUNT_W'((CW+1)'(r_f) + (CW+1)'(1));
                    e_last   = list_last;
                    if (r_func == FN_DELETE &&
                        32'(list_rdata) < 32'(DISK_SECTORS)) begin
                        map_we    = 1'b1;
                        map_waddr = MW'(list_rdata);
                        n_free    = r_free + MW'(1);
                    end
                    if (list_last) begin
                        dir_clr = (r_func == FN_DELETE);
                        n_state = S_IDLE;
                    end else begin
                        n_f     = r_f + CW'(1);
                        n_state = S_LIST_RD;
                    end
                end
            end
            S_ALLOC_RD: begin
                n_state = S_ALLOC_CHK;
            end
            S_ALLOC_CHK: begin
                if (map_rdata) begin
                    n_s     = r_s + SW'(1);
                    n_state = (r_s == S_END) ? S_IDLE : S_ALLOC_RD;
                end else if (can_emit) begin
                    emit      = 1'b1;
                    e_sec     = SECTOR_W'(r_s);
                    e_valid   = 1'b1;
                    e_count   = COUNT_W'((CW+1)'(r_f) + (CW+1)'(1));
                    e_last    = (32'(r_f) + 32'd1) == 32'(r_want);
                    map_we    = 1'b1;
                    map_wdata = 1'b1;
                    list_we   = 1'b1;
                    n_free    = r_free - MW'(1);
                    n_f       = r_f + CW'(1);
                    n_s       = r_s + SW'(1);
                    n_state   = e_last ? S_IDLE : S_ALLOC_RD;
                end
            end
            S_ERR: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    e_status = r_err;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid    = emit ? 1'b1 : (r_out_valid && !i_out_ready);
        n_sector       = emit ? e_sec    : r_sector;
        n_sector_valid = emit ? e_valid  : r_sector_valid;
        n_status       = emit ? e_status : r_status;
        n_count        = emit ? e_count  : r_count;
        n_last         = emit ? e_last   : r_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_sector       = r_sector;
    assign o_sector_valid = r_sector_valid;
    assign o_status       = r_status;
    assign o_count        = r_count;
    assign o_last         = r_last;
endmodule

// ===== sv/fdsa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fdsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/fdsa_checker.sv =====
// Port-level checks for the file directory sector allocator.
// Depends on fdsa_pkg; bound to file_directory_sector_allocator_core.
module fdsa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [fdsa_pkg::SECTOR_W-1:0] o_sector,
    input logic                          o_sector_valid,
    input logic [2:0]                    o_status,
    input logic [fdsa_pkg::COUNT_W-1:0]  o_count,
    input logic                          o_last
);
    import fdsa_pkg::*;

    // An error transaction is always a lone, empty one.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (!o_sector_valid && o_sector == '0 && o_count == '0 && o_last))
        else $error("error transaction carries sector data");

    // A sector is carried exactly when the running count is nonzero.
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sector_valid == (o_count != '0)))
        else $error("sector_valid and count disagree");

    // Within one operation the count rises by one per delivered transaction.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) ##1 o_out_valid |->
            (o_count == $past(o_count) + COUNT_W'(1) && o_sector != $past(o_sector)))
        else $error("count did not advance by one");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_sector) && $stable(o_count) && $stable(o_last)))
        else $error("stalled transaction changed");
endmodule

bind file_directory_sector_allocator_core fdsa_checker u_fdsa_checker (.*);

// ===== tb/tb_file_directory_sector_allocator_core.sv =====
// Testbench for file_directory_sector_allocator_core: directed and random
// lookup/create/delete traffic checked against a behavioral directory model.
// Depends on fdsa_pkg and the core RTL.
`timescale 1ns / 100ps

import fdsa_pkg::*;

typedef struct packed {
    logic [7:0] sector;
    logic       sector_valid;
    logic [2:0] status;
    logic [4:0] count;
    logic       last;
} t_sector_rsp;

class directory_scoreboard;
    logic [47:0] names [16];
    logic [7:0]  lists [16][26];
    bit          used_map [256];
    t_sector_rsp pending [$];
    int          errors;

    function new();
        for (int e = 0; e < 16; e++) begin
            names[e] = '0;
            for (int f = 0; f < 26; f++) lists[e][f] = '0;
        end
        for (int s = 0; s < 256; s++) used_map[s] = 1'b0;
        used_map[0] = 1'b1;
        errors = 0;
    endfunction

    function void push_rsp(logic [7:0] sec, logic vld, t_status st, int cnt, logic lst);
        t_sector_rsp r;
        r.sector = sec;
        r.sector_valid = vld;
        r.status = st;
        r.count = cnt[4:0];
        r.last = lst;
        pending.push_back(r);
    endfunction

    function logic [47:0] clean_name(logic [47:0] raw);
        logic [47:0] res;
        res = '0;
        for (int i = 0; i < 6; i++) begin
            if (raw[8*i +: 8] == 8'd0) break;
            res[8*i +: 8] = raw[8*i +: 8];
        end
        return res;
    endfunction

    // Works out every expected result of one accepted request.
    function void note_request(t_func fn, logic [47:0] raw, logic [4:0] want);
        logic [47:0] nm;
        int e, n, free_cnt;
        nm = clean_name(raw);
        if (fn == FN_NONE) return;
        if (nm[7:0] == 8'd0) begin
            push_rsp(0, 0, ST_BAD_NAME, 0, 1);
            return;
        end
        if (fn == FN_LOOKUP || fn == FN_DELETE) begin
            e = -1;
            for (int k = 0; k < 16; k++)
                if (e < 0 && names[k][7:0] != 0 && names[k] == nm) e = k;
            if (e < 0) begin
                push_rsp(0, 0, ST_NOT_FOUND, 0, 1);
                return;
            end
            n = 0;
            for (int f = 0; f < 26; f++) begin
                if (lists[e][f] == 0) break;
                n++;
            end
            if (n == 0) push_rsp(0, 0, ST_OK, 0, 1);
            for (int f = 0; f < n; f++) begin
                if (fn == FN_DELETE) used_map[lists[e][f]] = 1'b0;
                push_rsp(lists[e][f], 1, ST_OK, f + 1, f == n - 1);
            end
            if (fn == FN_DELETE) begin
                names[e] = '0;
                for (int f = 0; f < 26; f++) lists[e][f] = '0;
            end
            return;
        end
        if (want > 26) begin
            push_rsp(0, 0, ST_TOO_MANY, 0, 1);
            return;
        end
        free_cnt = 0;
        for (int s = 1; s < 256; s++) if (!used_map[s]) free_cnt++;
        if (free_cnt < want) begin
            push_rsp(0, 0, ST_NO_SPACE, 0, 1);
            return;
        end
        e = -1;
        for (int k = 0; k < 16; k++) if (e < 0 && names[k][7:0] == 0) e = k;
        if (e < 0) begin
            push_rsp(0, 0, ST_DIR_FULL, 0, 1);
            return;
        end
        names[e] = nm;
        for (int f = 0; f < 26; f++) lists[e][f] = '0;
        if (want == 0) begin
            push_rsp(0, 0, ST_OK, 0, 1);
            return;
        end
        n = 0;
        for (int s = 1; s < 256 && n < want; s++) begin
            if (!used_map[s]) begin
                used_map[s] = 1'b1;
                lists[e][n] = s[7:0];
                n++;
                push_rsp(s[7:0], 1, ST_OK, n, n == want);
            end
        end
    endfunction

    function void check_rsp(t_sector_rsp got);
        t_sector_rsp exp;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, got %p", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.sector !== exp.sector)
            $display("%0t: sector expected %0d actual %0d", $time, exp.sector, got.sector);
        if (got.sector_valid !== exp.sector_valid)
            $display("%0t: sector_valid expected %0b actual %0b", $time,
                     exp.sector_valid, got.sector_valid);
        if (got.status !== exp.status)
            $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        if (got.count !== exp.count)
            $display("%0t: count expected %0d actual %0d", $time, exp.count, got.count);
        if (got.last !== exp.last)
            $display("%0t: last expected %0b actual %0b", $time, exp.last, got.last);
        if (got !== exp) errors++;
    endfunction
endclass

module tb_file_directory_sector_allocator_core;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_func = '0;
    logic [47:0] i_file_name = '0;
    logic [4:0]  i_sector_count = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_sector;
    logic        o_sector_valid;
    logic [2:0]  o_status;
    logic [4:0]  o_count;
    logic        o_last;

    directory_scoreboard board = new();
    bit   calm_stretch = 1'b0;
    int   rx_hold = 0;
    logic [47:0] name_pool [8];

    file_directory_sector_allocator_core dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off requested by the sender.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_rsp('{o_sector, o_sector_valid, o_status, o_count, o_last});
        end
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm_stretch || ($urandom_range(99) >= 19);
        end
    end

    // Valid is dropped only while idling, so it gets one update per edge.
    task automatic send_request(t_func fn, logic [47:0] nm, logic [4:0] cnt);
        while (!calm_stretch && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_file_name <= nm;
        i_sector_count <= cnt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(fn, nm, cnt);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    function automatic logic [47:0] pick_name();
        logic [47:0] nm;
        if ($urandom_range(9) < 8) return name_pool[$urandom_range(7)];
        nm = 48'({$urandom, $urandom});
        // Sometimes cut the name short with a zero byte.
        if ($urandom_range(3) == 0) nm[8*$urandom_range(5) +: 8] = 8'd0;
        return nm;
    endfunction

    initial begin
        t_func fn;
        int r;
        for (int i = 0; i < 8; i++) name_pool[i] = 48'({$urandom, $urandom}) | 48'h1;
        name_pool[7] = 48'h0000_0000_0041;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases.
        send_request(FN_LOOKUP, name_pool[0], 0);
        send_request(FN_DELETE, name_pool[0], 0);
        send_request(FN_CREATE, 48'h0, 3);
        send_request(FN_LOOKUP, 48'hFFFF_FFFF_FF00, 0);
        send_request(FN_CREATE, name_pool[0], 27);
        send_request(FN_CREATE, name_pool[0], 31);
        send_request(FN_CREATE, 48'hFFFF_FFFF_FFFF, 26);
        send_request(FN_CREATE, name_pool[7], 0);
        send_request(FN_LOOKUP, 48'hFFFF_FFFF_0041, 0);
        send_request(FN_NONE, name_pool[1], 5);
        send_request(FN_CREATE, 48'hAA55_AA55_AA55, 5);
        send_request(FN_LOOKUP, 48'hFFFF_FFFF_FFFF, 0);
        send_request(FN_DELETE, name_pool[7], 0);
        for (int i = 0; i < 10; i++) send_request(FN_CREATE, name_pool[i % 7], 26);
        drain();
        for (int i = 0; i < 4; i++) send_request(FN_CREATE, 48'h0000_0000_5A00 + i + 1, 1);
        // Receiver holds off while requests keep coming.
        rx_hold <= 400;
        for (int i = 0; i < 5; i++) send_request(FN_LOOKUP, name_pool[i], 0);
        drain();
        send_request(FN_DELETE, 48'hFFFF_FFFF_FFFF, 0);

        for (int i = 0; i < 500; i++) begin
            if (i == 200) calm_stretch = 1'b1;
            if (i == 280) calm_stretch = 1'b0;
            if (i == 350) drain();
            r = $urandom_range(99);
            fn = (r < 35) ? FN_CREATE : (r < 65) ? FN_LOOKUP : (r < 95) ? FN_DELETE : FN_NONE;
            send_request(fn, pick_name(),
                         ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                  : 5'($urandom_range(12)));
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== file_directory_sector_allocator_core.f =====
sv/fdsa_pkg.sv
sv/fdsa_ram.sv
sv/file_directory_sector_allocator_core.sv
sv/fdsa_checker.sv
tb/tb_file_directory_sector_allocator_core.sv
